// ===== rtl/tpue_pkg.sv =====
// ----------------------------------------------------------------------------
// Pheromone update engine package
// Shared constants, operation codes and fixed-point widths.
// ----------------------------------------------------------------------------
package tpue_pkg;

  // Default configuration of the engine.
  localparam int CITIES_DEF    = 64;
  localparam int DIST_BITS_DEF = 16;

  // Fixed field widths.
  localparam int OP_W     = 3;
  localparam int CITY_W   = 6;
  localparam int DATA_W   = 32;
  localparam int LEN_W    = 22;
  localparam int RETAIN_W = 16;

  // Saturation limit of the tour length and reset value of the retain factor.
  localparam logic [LEN_W-1:0]    LEN_MAX      = 22'h3FFFFF;
  localparam logic [RETAIN_W-1:0] RETAIN_RESET = 16'h8000;

  // Divider runs over the 25 bits of 1.0 in Q8.24.
  localparam int          QUO_W   = 25;
  localparam logic [4:0]  DIV_TOP = 5'd24;

  // Request operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_WR_DIST = 3'd0,
    OP_WR_PHER = 3'd1,
    OP_RD_PHER = 3'd2,
    OP_CITY    = 3'd3,
    OP_EVAP    = 3'd4
  } op_t;

endpackage

// ===== rtl/tpue_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module tpue_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read with the output held between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tsp_pheromone_update_engine_top.sv =====
// ----------------------------------------------------------------------------
// Ant-system pheromone update engine
// Distance and pheromone matrices in RAM, tour length, deposit, evaporation.
// ----------------------------------------------------------------------------
// Usage: requests enter on in_valid/in_ready, one result per request leaves on
// out_valid/out_ready. The engine works on one request at a time; in_ready is
// high while it waits for a request, also while a result waits to be taken.
// Matrix writes and pheromone reads go from S_IDLE straight to S_EMIT. A tour
// city after the first reads its edge distance and adds it in S_CITY_ADD. The
// last city of a tour adds the closing edge, runs a one-bit-per-cycle
// divider for 1/length (skipped for length zero), then walks the tour edges
// through the pheromone RAM in S_DEP_BUF, S_DEP_RD and S_DEP_WR, the closing
// edge in S_CL_RD and S_CL_WR. Evaporation sweeps the pheromone RAM one entry
// per cycle. Reset clears the tour state and sets the retain factor to one
// half; the matrices hold nothing defined until written. A stalled receiver
// holds the result register, and the engine stops before its next result
// until the register is free. cfg_we writes the retain factor; the user must
// assert it only while the engine is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module tsp_pheromone_update_engine_top #(
  parameter int CITIES    = tpue_pkg::CITIES_DEF,
  parameter int DIST_BITS = tpue_pkg::DIST_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tpue_pkg::RETAIN_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tpue_pkg::OP_W-1:0]     operation,
  input  logic [tpue_pkg::CITY_W-1:0]   row_city,
  input  logic [tpue_pkg::CITY_W-1:0]   col_city,
  input  logic [tpue_pkg::DATA_W-1:0]   write_value,
  input  logic [tpue_pkg::CITY_W-1:0]   tour_city,
  input  logic                          last_of_tour,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tpue_pkg::DATA_W-1:0]   read_data,
  output logic [tpue_pkg::LEN_W-1:0]    tour_length,
  output logic                          tour_done,
  output logic                          status
);
  import tpue_pkg::*;

  localparam int CW   = (CITIES > 1) ? $clog2(CITIES) : 1;
  localparam int NN   = CITIES * CITIES;
  localparam int MW   = $clog2(NN);
  localparam int EVW  = $clog2(NN + 1);
  localparam int CNTW = $clog2(CITIES + 1);
  localparam int SUMW = ((LEN_W > DIST_BITS) ? LEN_W : DIST_BITS) + 1;
  localparam logic [DATA_W:0] DMAX = (33'd1 << DIST_BITS) - 33'd1;

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_EMIT      = 12'b0000_0000_0010,
    S_CITY_ADD  = 12'b0000_0000_0100,
    S_CLOSE_RD  = 12'b0000_0000_1000,
    S_CLOSE_ADD = 12'b0000_0001_0000,
    S_DIV       = 12'b0000_0010_0000,
    S_DEP_BUF   = 12'b0000_0100_0000,
    S_DEP_RD    = 12'b0000_1000_0000,
    S_DEP_WR    = 12'b0001_0000_0000,
    S_CL_RD     = 12'b0010_0000_0000,
    S_CL_WR     = 12'b0100_0000_0000,
    S_EVAP      = 12'b1000_0000_0000
  } state_t;

  state_t state;

  // Tour state.
  logic [CNTW-1:0]      tour_count;
  logic [LEN_W-1:0]     acc;
  logic                 ovf;
  logic                 last_flag;
  logic [CW-1:0]        prev_city;
  logic [CW-1:0]        first_city;
  logic [RETAIN_W-1:0]  retain_factor;

  // Divider and deposit walk.
  logic [LEN_W-1:0]     len;
  logic [LEN_W-1:0]     rem;
  logic [QUO_W-1:0]     quo;
  logic [4:0]           div_cnt;
  logic [DATA_W-1:0]    delta;
  logic [CNTW-1:0]      walk_idx;
  logic [CW-1:0]        walk_prev;
  logic [CW-1:0]        walk_cur;

  // Evaporation pipeline.
  logic [EVW-1:0]       ev_rd_idx;
  logic                 ev_v1;
  logic                 ev_v2;
  logic [MW-1:0]        ev_a1;
  logic [MW-1:0]        ev_a2;
  logic [DATA_W-1:0]    ev_prod;

  // Pending result fields.
  logic                 res_rd_sel;
  logic [LEN_W-1:0]     res_len;
  logic                 res_done;
  logic                 res_status;

  // RAM ports.
  logic                 d_we, d_re, p_we, p_re, t_we, t_re;
  logic [MW-1:0]        d_waddr, d_raddr, p_waddr, p_raddr;
  logic [CW-1:0]        t_waddr, t_raddr;
  logic [DIST_BITS-1:0] d_wdata, dist_rdata;
  logic [DATA_W-1:0]    p_wdata, ph_rdata;
  logic [CW-1:0]        tbuf_rdata;

  // Datapath signals.
  logic                 in_fire;
  logic [CW-1:0]        row_m, col_m, city_m;
  logic [CW-1:0]        mod_tbl [2**CITY_W];
  logic [SUMW-1:0]      acc_sum;
  logic [LEN_W-1:0]     acc_sat;
  logic [DATA_W:0]      ph_sum;
  logic [DATA_W-1:0]    ph_sat;
  logic [LEN_W:0]       rem_sh;
  logic                 div_ge;
  logic [LEN_W-1:0]     rem_n;
  logic [QUO_W-1:0]     quo_n;
  logic [47:0]          prod_full;
  logic                 ev_issue;
  logic                 tour_full;
  state_t               dep_start;

  function automatic logic [MW-1:0] mat_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return MW'(r) * MW'(CITIES) + MW'(c);
  endfunction

  // City indexes reduce modulo the city count through a constant table.
  for (genvar g = 0; g < 2**CITY_W; g++) begin : g_mod
    assign mod_tbl[g] = CW'(g % CITIES);
  end

  assign row_m     = mod_tbl[row_city];
  assign col_m     = mod_tbl[col_city];
  assign city_m    = mod_tbl[tour_city];
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign tour_full = (tour_count >= CNTW'(CITIES));
  assign dep_start = (tour_count > CNTW'(1)) ? S_DEP_BUF : S_CL_RD;

  // Saturating length add and saturating pheromone deposit.
  assign acc_sum = SUMW'(acc) + SUMW'(dist_rdata);
  assign acc_sat = (acc_sum > SUMW'(LEN_MAX)) ? LEN_MAX : acc_sum[LEN_W-1:0];
  assign ph_sum  = {1'b0, ph_rdata} + {1'b0, delta};
  assign ph_sat  = ph_sum[DATA_W] ? '1 : ph_sum[DATA_W-1:0];

  // One restoring step of 1.0 (Q8.24) divided by the tour length.
  assign rem_sh = {rem, (div_cnt == DIV_TOP)};
  assign div_ge = (rem_sh >= {1'b0, len});
  assign rem_n  = div_ge ? LEN_W'(rem_sh - {1'b0, len}) : rem_sh[LEN_W-1:0];
  assign quo_n  = {quo[QUO_W-2:0], div_ge};

  // Evaporation product with the retain factor in Q0.16.
  assign prod_full = {16'b0, ph_rdata} * {32'b0, retain_factor};
  assign ev_issue  = (ev_rd_idx < EVW'(NN));

  // RAM port selection by state.
  always_comb begin
    d_we = 1'b0; d_waddr = '0; d_wdata = '0; d_re = 1'b0; d_raddr = '0;
    p_we = 1'b0; p_waddr = '0; p_wdata = '0; p_re = 1'b0; p_raddr = '0;
    t_we = 1'b0; t_waddr = '0; t_re = 1'b0; t_raddr = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (op_t'(operation))
            OP_WR_DIST: begin
              d_we    = 1'b1;
              d_waddr = mat_addr(row_m, col_m);
              d_wdata = ({1'b0, write_value} > DMAX) ? DMAX[DIST_BITS-1:0]
                                                     : write_value[DIST_BITS-1:0];
            end
            OP_WR_PHER: begin
              p_we    = 1'b1;
              p_waddr = mat_addr(row_m, col_m);
              p_wdata = write_value;
            end
            OP_RD_PHER: begin
              p_re    = 1'b1;
              p_raddr = mat_addr(row_m, col_m);
            end
            OP_CITY: begin
              if (!tour_full) begin
                t_we    = 1'b1;
                t_waddr = tour_count[CW-1:0];
                if (tour_count != '0) begin
                  d_re    = 1'b1;
                  d_raddr = mat_addr(prev_city, city_m);
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_CLOSE_RD: begin
        d_re    = 1'b1;
        d_raddr = mat_addr(prev_city, first_city);
      end
      S_DEP_BUF: begin
        t_re    = 1'b1;
        t_raddr = walk_idx[CW-1:0];
      end
      S_DEP_RD: begin
        p_re    = 1'b1;
        p_raddr = mat_addr(walk_prev, tbuf_rdata);
      end
      S_DEP_WR: begin
        p_we    = 1'b1;
        p_waddr = mat_addr(walk_prev, walk_cur);
        p_wdata = ph_sat;
      end
      S_CL_RD: begin
        p_re    = 1'b1;
        p_raddr = mat_addr(prev_city, first_city);
      end
      S_CL_WR: begin
        p_we    = 1'b1;
        p_waddr = mat_addr(prev_city, first_city);
        p_wdata = ph_sat;
      end
      S_EVAP: begin
        p_re    = ev_issue;
        p_raddr = ev_rd_idx[MW-1:0];
        p_we    = ev_v2;
        p_waddr = ev_a2;
        p_wdata = ev_prod;
      end
      default: ;
    endcase
  end

  // Sequencer and registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      tour_count    <= '0;
      acc           <= '0;
      ovf           <= 1'b0;
      retain_factor <= RETAIN_RESET;
      out_valid     <= 1'b0;
      ev_v1         <= 1'b0;
      ev_v2         <= 1'b0;
    end else begin
      if (cfg_we) begin
        retain_factor <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            res_rd_sel <= 1'b0;
            res_len    <= '0;
            res_done   <= 1'b0;
            res_status <= 1'b0;
            case (op_t'(operation))
              OP_RD_PHER: begin
                res_rd_sel <= 1'b1;
                state      <= S_EMIT;
              end
              OP_CITY: begin
                last_flag <= last_of_tour;
                if (!tour_full) begin
                  tour_count <= tour_count + CNTW'(1);
                  prev_city  <= city_m;
                  res_status <= ovf;
                  if (tour_count == '0) begin
                    first_city <= city_m;
                    state      <= last_of_tour ? S_CLOSE_RD : S_EMIT;
                  end else begin
                    state <= S_CITY_ADD;
                  end
                end else begin
                  ovf        <= 1'b1;
                  res_status <= 1'b1;
                  state      <= last_of_tour ? S_CLOSE_RD : S_EMIT;
                end
              end
              OP_EVAP: begin
                ev_rd_idx <= '0;
                state     <= S_EVAP;
              end
              default: begin
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            read_data   <= res_rd_sel ? ph_rdata : '0;
            tour_length <= res_len;
            tour_done   <= res_done;
            status      <= res_status;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_CITY_ADD: begin
          acc   <= acc_sat;
          state <= last_flag ? S_CLOSE_RD : S_EMIT;
        end
        S_CLOSE_RD: begin
          state <= S_CLOSE_ADD;
        end
        S_CLOSE_ADD: begin
          res_len   <= acc_sat;
          res_done  <= 1'b1;
          len       <= acc_sat;
          walk_idx  <= CNTW'(1);
          walk_prev <= first_city;
          if (acc_sat == '0) begin
            delta <= '1;
            state <= dep_start;
          end else begin
            rem     <= '0;
            quo     <= '0;
            div_cnt <= DIV_TOP;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem     <= rem_n;
          quo     <= quo_n;
          div_cnt <= div_cnt - 5'd1;
          if (div_cnt == '0) begin
            delta <= DATA_W'(quo_n);
            state <= dep_start;
          end
        end
        S_DEP_BUF: begin
          state <= S_DEP_RD;
        end
        S_DEP_RD: begin
          walk_cur <= tbuf_rdata;
          state    <= S_DEP_WR;
        end
        S_DEP_WR: begin
          walk_prev <= walk_cur;
          if (walk_idx == tour_count - CNTW'(1)) begin
            state <= S_CL_RD;
          end else begin
            walk_idx <= walk_idx + CNTW'(1);
            state    <= S_DEP_BUF;
          end
        end
        S_CL_RD: begin
          state <= S_CL_WR;
        end
        S_CL_WR: begin
          tour_count <= '0;
          acc        <= '0;
          ovf        <= 1'b0;
          state      <= S_EMIT;
        end
        S_EVAP: begin
          // Read, scale and write back one entry per cycle.
          ev_v1   <= ev_issue;
          ev_a1   <= ev_rd_idx[MW-1:0];
          ev_v2   <= ev_v1;
          ev_a2   <= ev_a1;
          ev_prod <= prod_full[47:16];
          if (ev_issue) begin
            ev_rd_idx <= ev_rd_idx + EVW'(1);
          end else if (!ev_v1 && !ev_v2) begin
            state <= S_EMIT;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Distance matrix.
  tpue_ram #(.WIDTH(DIST_BITS), .DEPTH(NN)) u_dist_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .re(d_re), .raddr(d_raddr), .rdata(dist_rdata)
  );

  // Pheromone matrix.
  tpue_ram #(.WIDTH(DATA_W), .DEPTH(NN)) u_pher_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .re(p_re), .raddr(p_raddr), .rdata(ph_rdata)
  );

  // Tour city buffer.
  tpue_ram #(.WIDTH(CW), .DEPTH(CITIES)) u_tour_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(city_m),
    .re(t_re), .raddr(t_raddr), .rdata(tbuf_rdata)
  );

  // The tour buffer never holds more cities than it has entries.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    tour_count <= CNTW'(CITIES))
    else $error("tour count beyond city count");

  // Evaporation write-backs only happen inside the sweep.
  a_evap_write: assert property (@(posedge clk) disable iff (rst)
    ev_v2 |-> state == S_EVAP)
    else $error("evaporation write outside sweep");

  // A completed tour never carries read data.
  a_done_no_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && tour_done |-> read_data == '0)
    else $error("tour result with read data");

endmodule
